// ===== sv/ecu_pkg.sv =====
package ecu_pkg;

  typedef struct packed {
    logic saturated;
    logic degenerate;
  } flags_t;

endpackage

// ===== sv/enclosing_circle_update_core.sv =====
// Grows a circle to reach a given point by one Kallberg-Larsson step on raw
// fixed-point integers: h = floor(sqrt(dx^2+dy^2)), r' = floor((r^2+h^2)/(2h)),
// center' = far + sign(d)*floor(r'*|d|/h), clipped per field. A point equal
// to the center passes the circle through with the degenerate flag set.
// Fully pipelined: one word accepted every cycle unless the output stalls;
// the path runs through the bit-per-stage square root and the two chained
// bit-per-stage dividers. A stall at the output holds the whole
// pipeline in place.
module enclosing_circle_update_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // center_x, center_y, radius_in, far_x, far_y
  input  logic [((5*COORD_WIDTH+7)/8)*8-1:0]        in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // new_center_x, new_center_y, new_radius
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]        out_tdata,
  // degenerate, saturated
  output ecu_pkg::flags_t                           out_tuser
);

  import ecu_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int HW    = W + 1;
  localparam int SQW   = 2 * HW;
  localparam int DVW   = HW + 1;
  localparam int OTW   = ((3*W+7)/8)*8;
  localparam int SA_W  = 5*W + 2 + 2*HW;
  localparam int SB_W  = SA_W + HW;
  localparam int SX_W  = 2*W + 3 + W;
  localparam int SY_W  = 3*W + 1;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: input register
  logic         s1_v_r;
  logic [W-1:0] s1_cx_r, s1_cy_r, s1_r_r, s1_fx_r, s1_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cx_r <= in_tdata[W-1:0];
      s1_cy_r <= in_tdata[2*W-1:W];
      s1_r_r  <= in_tdata[3*W-1:2*W];
      s1_fx_r <= in_tdata[4*W-1:3*W];
      s1_fy_r <= in_tdata[5*W-1:4*W];
    end
  end

  // stage 2: differences and magnitudes
  logic [HW-1:0] dx, dy;
  assign dx = {s1_cx_r[W-1], s1_cx_r} - {s1_fx_r[W-1], s1_fx_r};
  assign dy = {s1_cy_r[W-1], s1_cy_r} - {s1_fy_r[W-1], s1_fy_r};

  logic          s2_v_r;
  logic [W-1:0]  s2_cx_r, s2_cy_r, s2_r_r, s2_fx_r, s2_fy_r;
  logic          s2_sx_r, s2_sy_r;
  logic [HW-1:0] s2_adx_r, s2_ady_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cx_r  <= s1_cx_r;
      s2_cy_r  <= s1_cy_r;
      s2_r_r   <= s1_r_r;
      s2_fx_r  <= s1_fx_r;
      s2_fy_r  <= s1_fy_r;
      s2_sx_r  <= dx[W];
      s2_sy_r  <= dy[W];
      s2_adx_r <= dx[W] ? (~dx + 1'b1) : dx;
      s2_ady_r <= dy[W] ? (~dy + 1'b1) : dy;
    end
  end

  // stage 3: squares
  logic            s3_v_r;
  logic [SQW-1:0]  s3_sqx_r, s3_sqy_r;
  logic [SA_W-1:0] s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sqx_r  <= SQW'(s2_adx_r) * SQW'(s2_adx_r);
      s3_sqy_r  <= SQW'(s2_ady_r) * SQW'(s2_ady_r);
      s3_side_r <= {s2_cx_r, s2_cy_r, s2_r_r, s2_fx_r, s2_fy_r,
                    s2_sx_r, s2_sy_r, s2_adx_r, s2_ady_r};
    end
  end

  // stage 4: sum of squares
  logic            s4_v_r;
  logic [SQW-1:0]  s4_sum_r;
  logic [SA_W-1:0] s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sum_r  <= s3_sqx_r + s3_sqy_r;
      s4_side_r <= s3_side_r;
    end
  end

  logic            sq_v;
  logic [HW-1:0]   sq_h;
  logic [SA_W-1:0] sq_side;

  ecu_sqrt #(.N(HW), .SW(SA_W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_rad    (s4_sum_r),
    .in_side   (s4_side_r),
    .out_valid (sq_v),
    .out_root  (sq_h),
    .out_side  (sq_side)
  );

  // stage 5: r*r and h*h
  logic [W-1:0] sq_r;
  assign sq_r = sq_side[SA_W-2*W-1:SA_W-3*W];

  logic            s5_v_r;
  logic [2*W-1:0]  s5_rr_r;
  logic [SQW-1:0]  s5_hh_r;
  logic [HW-1:0]   s5_h_r;
  logic [SA_W-1:0] s5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_rr_r   <= (2*W)'(sq_r) * (2*W)'(sq_r);
      s5_hh_r   <= SQW'(sq_h) * SQW'(sq_h);
      s5_h_r    <= sq_h;
      s5_side_r <= sq_side;
    end
  end

  // stage 6: numerator, divisor and overflow test
  logic [SQW-1:0] rnum;
  logic [DVW-1:0] rden;
  logic           rovf;
  assign rnum = SQW'(s5_rr_r) + s5_hh_r;
  assign rden = {s5_h_r, 1'b0};
  assign rovf = (rnum[SQW-1:W] >= rden);

  logic            s6_v_r;
  logic [DVW-1:0]  s6_rem_r;
  logic [W-1:0]    s6_lo_r;
  logic [DVW-1:0]  s6_den_r;
  logic [SB_W+1:0] s6_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_rem_r  <= rovf ? '0 : rnum[SQW-1:W];
      s6_lo_r   <= rnum[W-1:0];
      s6_den_r  <= rden;
      s6_side_r <= {s5_side_r, s5_h_r, rovf, (s5_h_r == '0)};
    end
  end

  logic            d1_v;
  logic [W-1:0]    d1_q;
  logic [SB_W+1:0] d1_side;

  ecu_div #(.QW(W), .DW(DVW), .SW(SB_W+2)) u_div_rad (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s6_v_r),
    .in_rem    (s6_rem_r),
    .in_num    (s6_lo_r),
    .in_den    (s6_den_r),
    .in_side   (s6_side_r),
    .out_valid (d1_v),
    .out_quo   (d1_q),
    .out_side  (d1_side)
  );

  logic [W-1:0]  d1_cx, d1_cy, d1_r, d1_fx, d1_fy;
  logic          d1_sx, d1_sy, d1_ovf, d1_degen;
  logic [HW-1:0] d1_adx, d1_ady, d1_h;
  assign {d1_cx, d1_cy, d1_r, d1_fx, d1_fy, d1_sx, d1_sy, d1_adx, d1_ady,
          d1_h, d1_ovf, d1_degen} = d1_side;

  // stage 7: clipped radius times each offset
  logic [W-1:0] rn;
  assign rn = d1_ovf ? '1 : d1_q;

  logic            s7_v_r;
  logic [2*W:0]    s7_px_r, s7_py_r;
  logic [HW-1:0]   s7_h_r;
  logic [SX_W-1:0] s7_xside_r;
  logic [SY_W-1:0] s7_yside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_px_r    <= (2*W+1)'(rn) * (2*W+1)'(d1_adx);
      s7_py_r    <= (2*W+1)'(rn) * (2*W+1)'(d1_ady);
      s7_h_r     <= d1_h;
      s7_xside_r <= {d1_cx, d1_fx, d1_sx, rn, d1_ovf, d1_degen};
      s7_yside_r <= {d1_cy, d1_fy, d1_sy, d1_r};
    end
  end

  logic            dx_v, dy_v;
  logic [W-1:0]    tx, ty;
  logic [SX_W-1:0] xside;
  logic [SY_W-1:0] yside;

  ecu_div #(.QW(W), .DW(HW), .SW(SX_W)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s7_v_r),
    .in_rem    (s7_px_r[2*W:W]),
    .in_num    (s7_px_r[W-1:0]),
    .in_den    (s7_h_r),
    .in_side   (s7_xside_r),
    .out_valid (dx_v),
    .out_quo   (tx),
    .out_side  (xside)
  );

  ecu_div #(.QW(W), .DW(HW), .SW(SY_W)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s7_v_r),
    .in_rem    (s7_py_r[2*W:W]),
    .in_num    (s7_py_r[W-1:0]),
    .in_den    (s7_h_r),
    .in_side   (s7_yside_r),
    .out_valid (dy_v),
    .out_quo   (ty),
    .out_side  (yside)
  );

  logic [W-1:0] f_cx, f_fx, f_rn, f_cy, f_fy, f_r;
  logic         f_sx, f_ovf, f_degen, f_sy;
  assign {f_cx, f_fx, f_sx, f_rn, f_ovf, f_degen} = xside;
  assign {f_cy, f_fy, f_sy, f_r} = yside;

  // final: offset, clip and select
  localparam logic signed [W+1:0] MAXV = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] MINV = {3'b111, {(W-1){1'b0}}};

  logic signed [W+1:0] vx, vy;
  logic                hix, lox, hiy, loy;
  logic [W-1:0]        nx, ny;

  always_comb begin
    vx  = f_sx ? ($signed({{2{f_fx[W-1]}}, f_fx}) - $signed({2'b00, tx}))
               : ($signed({{2{f_fx[W-1]}}, f_fx}) + $signed({2'b00, tx}));
    vy  = f_sy ? ($signed({{2{f_fy[W-1]}}, f_fy}) - $signed({2'b00, ty}))
               : ($signed({{2{f_fy[W-1]}}, f_fy}) + $signed({2'b00, ty}));
    hix = (vx > MAXV);
    lox = (vx < MINV);
    hiy = (vy > MAXV);
    loy = (vy < MINV);
    nx  = hix ? MAXV[W-1:0] : (lox ? MINV[W-1:0] : vx[W-1:0]);
    ny  = hiy ? MAXV[W-1:0] : (loy ? MINV[W-1:0] : vy[W-1:0]);
  end

  logic         out_v_r;
  logic [W-1:0] ox_r, oy_r, or_r;
  flags_t       oflags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dx_v && dy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f_degen) begin
        ox_r                <= f_cx;
        oy_r                <= f_cy;
        or_r                <= f_r;
        oflags_r.degenerate <= 1'b1;
        oflags_r.saturated  <= 1'b0;
      end else begin
        ox_r                <= nx;
        oy_r                <= ny;
        or_r                <= f_rn;
        oflags_r.degenerate <= 1'b0;
        oflags_r.saturated  <= f_ovf || hix || lox || hiy || loy;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OTW'({or_r, oy_r, ox_r});
  assign out_tuser  = oflags_r;

endmodule

// ===== sv/ecu_sqrt.sv =====
module ecu_sqrt #(
  parameter int N  = 33,
  parameter int SW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2*N-1:0]   in_rad,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [N-1:0]     out_root,
  output logic [SW-1:0]    out_side
);

  logic [N:0]       valid_r;
  logic [2*N-1:0]   rad_r  [N+1];
  logic [N:0]       rem_r  [N+1];
  logic [N-1:0]     root_r [N+1];
  logic [SW-1:0]    side_r [N+1];

  assign valid_r[0] = in_valid;
  assign rad_r[0]   = in_rad;
  assign rem_r[0]   = '0;
  assign root_r[0]  = '0;
  assign side_r[0]  = in_side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N+2:0] cur;
    logic [N+2:0] trial;
    logic [N+2:0] diff;
    logic         ge;
    logic [N:0]   rem_nxt;

    always_comb begin
      cur     = {rem_r[i], rad_r[i][2*N-1:2*N-2]};
      trial   = {1'b0, root_r[i], 2'b01};
      diff    = cur - trial;
      ge      = (cur >= trial);
      rem_nxt = ge ? diff[N:0] : cur[N:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else if (en) begin
        valid_r[i+1] <= valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i+1]  <= {rad_r[i][2*N-3:0], 2'b00};
        rem_r[i+1]  <= rem_nxt;
        root_r[i+1] <= {root_r[i][N-2:0], ge};
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = valid_r[N];
  assign out_root  = root_r[N];
  assign out_side  = side_r[N];

endmodule

// ===== sv/ecu_div.sv =====
module ecu_div #(
  parameter int QW = 32,
  parameter int DW = 34,
  parameter int SW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [DW-1:0]  in_rem,
  input  logic [QW-1:0]  in_num,
  input  logic [DW-1:0]  in_den,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [QW-1:0]  out_quo,
  output logic [SW-1:0]  out_side
);

  logic [QW:0]     valid_r;
  logic [DW-1:0]   rem_r  [QW+1];
  logic [QW-1:0]   nq_r   [QW+1];
  logic [DW-1:0]   den_r  [QW+1];
  logic [SW-1:0]   side_r [QW+1];

  assign valid_r[0] = in_valid;
  assign rem_r[0]   = in_rem;
  assign nq_r[0]    = in_num;
  assign den_r[0]   = in_den;
  assign side_r[0]  = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0]   cur;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    always_comb begin
      cur     = {rem_r[i], nq_r[i][QW-1]};
      diff    = cur - {1'b0, den_r[i]};
      ge      = (cur >= {1'b0, den_r[i]});
      rem_nxt = ge ? diff[DW-1:0] : cur[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else if (en) begin
        valid_r[i+1] <= valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= rem_nxt;
        nq_r[i+1]   <= {nq_r[i][QW-2:0], ge};
        den_r[i+1]  <= den_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = valid_r[QW];
  assign out_quo   = nq_r[QW];
  assign out_side  = side_r[QW];

endmodule
